@@ src/assert_macros.svh @@
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, masked during reset.
`define ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk, masked during reset.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ src/nalfu_pkg.sv @@
// Package: widths, register indexes, FU-A constants and shared types.
package nalfu_pkg;

    localparam int NAL_BYTE_W  = 8;
    localparam int UNIT_LEN_W  = 24;
    localparam int LIMIT_W     = 11;
    localparam int STEP_W      = 17;
    localparam int SEQ_W       = 16;
    localparam int TS_W        = 32;
    localparam int CFG_DATA_W  = 17;
    localparam int CFG_INDEX_W = 1;
    localparam int MAX_RESULTS = 3;
    localparam int RES_CNT_W   = 2;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FRAGMENT_LIMIT = 1'b0,
        CFG_TIMESTAMP_STEP = 1'b1
    } cfg_index_t;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1400;
    localparam logic [STEP_W-1:0]  STEP_RESET  = 17'd3600;

    // NAL header and FU-A field constants
    localparam logic [NAL_BYTE_W-1:0] F_NRI_MASK = 8'hE0;
    localparam logic [NAL_BYTE_W-1:0] TYPE_MASK  = 8'h1F;
    localparam logic [NAL_BYTE_W-1:0] FU_A_TYPE  = 8'd28;
    localparam logic [NAL_BYTE_W-1:0] FLAG_START = 8'h80;
    localparam logic [NAL_BYTE_W-1:0] FLAG_END   = 8'h40;

    // One payload byte waiting for the output side
    typedef struct packed {
        logic [NAL_BYTE_W-1:0] data;
        logic                  first;
        logic                  last;
    } slot_t;

    // Everything one accepted item produces
    typedef struct packed {
        logic [RES_CNT_W-1:0]        count;
        slot_t [MAX_RESULTS-1:0]     slots;
        logic [SEQ_W-1:0]            seq;
        logic [TS_W-1:0]             ts;
    } step_result_t;

endpackage

@@ src/nalfu_ifs.sv @@
// Valid/ready channel interfaces for NAL input bytes and RTP payload bytes.
interface nalfu_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [nalfu_pkg::NAL_BYTE_W-1:0]     nal_byte;
    logic                                 first_of_unit;
    logic [nalfu_pkg::UNIT_LEN_W-1:0]     unit_length;

    modport source (output valid, output nal_byte, output first_of_unit,
                    output unit_length, input ready);
    modport sink   (input valid, input nal_byte, input first_of_unit,
                    input unit_length, output ready);
endinterface

interface nalfu_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [nalfu_pkg::NAL_BYTE_W-1:0]     payload_byte;
    logic                                 packet_first;
    logic                                 packet_last;
    logic [nalfu_pkg::SEQ_W-1:0]          sequence_number;
    logic [nalfu_pkg::TS_W-1:0]           time_stamp;
    logic                                 run_last;

    modport source (output valid, output payload_byte, output packet_first,
                    output packet_last, output sequence_number,
                    output time_stamp, output run_last, input ready);
    modport sink   (input valid, input payload_byte, input packet_first,
                    input packet_last, input sequence_number,
                    input time_stamp, input run_last, output ready);
endinterface

@@ src/nalfu_step.sv @@
// Packetizer state, configuration registers and the per-byte step logic.
module nalfu_step #(
    parameter int MAX_UNIT_LENGTH_BITS = 24
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [nalfu_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [nalfu_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                 accept,
    input  logic [nalfu_pkg::NAL_BYTE_W-1:0]     nal_byte,
    input  logic                                 first_of_unit,
    input  logic [nalfu_pkg::UNIT_LEN_W-1:0]     unit_length,
    output nalfu_pkg::step_result_t              result
);
    import nalfu_pkg::*;

    localparam int LEN_W = (MAX_UNIT_LENGTH_BITS > UNIT_LEN_W) ?
                           UNIT_LEN_W : MAX_UNIT_LENGTH_BITS;

    logic [LIMIT_W-1:0]    limit_reg;
    logic [STEP_W-1:0]     step_reg;
    logic                  frag_mode_reg, frag_mode_next;
    logic [NAL_BYTE_W-1:0] header_reg, header_next;
    logic [LEN_W-1:0]      unit_left_reg, unit_left_next;
    logic [LIMIT_W-1:0]    frag_left_reg, frag_left_next;
    logic                  start_pend_reg, start_pend_next;
    logic [SEQ_W-1:0]      seq_reg, seq_next;
    logic [TS_W-1:0]       ts_reg, ts_next;

    logic [LIMIT_W-1:0]    lim;
    logic [LEN_W-1:0]      lim_ext;
    logic [LEN_W-1:0]      len;
    logic [LEN_W-1:0]      unit_left_dec;
    logic [LIMIT_W-1:0]    frag_size;
    logic [LIMIT_W-1:0]    frag_left_dec;
    logic                  abandon;
    logic                  seq_bump;
    logic                  unit_done;
    logic [SEQ_W-1:0]      seq_cur;
    logic [TS_W-1:0]       ts_cur;
    logic [NAL_BYTE_W-1:0] fu_ind;
    logic [NAL_BYTE_W-1:0] fu_hdr;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
            step_reg  <= STEP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_FRAGMENT_LIMIT: limit_reg <= cfg_data[LIMIT_W-1:0];
                CFG_TIMESTAMP_STEP: step_reg  <= cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // Step logic: results of one byte and the state it leaves
    always_comb
    begin
        lim           = (limit_reg == '0) ? LIMIT_W'(1) : limit_reg;
        lim_ext       = LEN_W'(lim);
        len           = unit_length[LEN_W-1:0];
        unit_left_dec = unit_left_reg - LEN_W'(1);
        fu_ind        = (header_reg & F_NRI_MASK) | FU_A_TYPE;
        fu_hdr        = header_reg & TYPE_MASK;
        frag_size     = lim;
        frag_left_dec = frag_left_reg - LIMIT_W'(1);

        // abandoned unit closes its timestamp and maybe skips its packet
        abandon  = first_of_unit && (unit_left_reg != '0);
        seq_cur  = seq_reg + SEQ_W'(abandon && (!frag_mode_reg || frag_left_reg != '0));
        ts_cur   = ts_reg + (abandon ? TS_W'(step_reg) : '0);

        seq_bump        = 1'b0;
        unit_done       = 1'b0;
        frag_mode_next  = frag_mode_reg;
        header_next     = header_reg;
        unit_left_next  = unit_left_reg;
        frag_left_next  = frag_left_reg;
        start_pend_next = start_pend_reg;
        result.count    = '0;
        result.slots    = '0;

        if (first_of_unit)
        begin
            if (len == '0)
                len = LEN_W'(1);
            header_next     = nal_byte;
            frag_left_next  = '0;
            start_pend_next = 1'b0;
            unit_left_next  = len - LEN_W'(1);
            if (len <= lim_ext)
            begin
                frag_mode_next = 1'b0;
                result.count   = RES_CNT_W'(1);
                result.slots[0] = '{data: nal_byte, first: 1'b1, last: (len == LEN_W'(1))};
                if (len == LEN_W'(1))
                begin
                    seq_bump  = 1'b1;
                    unit_done = 1'b1;
                end
            end
            else
            begin
                frag_mode_next  = 1'b1;
                start_pend_next = 1'b1;
                // two-byte unit with limit one: bare start fragment now
                if (unit_left_next == LEN_W'(1))
                begin
                    result.count    = RES_CNT_W'(2);
                    result.slots[0] = '{data: (nal_byte & F_NRI_MASK) | FU_A_TYPE,
                                        first: 1'b1, last: 1'b0};
                    result.slots[1] = '{data: FLAG_START | (nal_byte & TYPE_MASK),
                                        first: 1'b0, last: 1'b1};
                    seq_bump        = 1'b1;
                    start_pend_next = 1'b0;
                end
            end
        end
        else if (unit_left_reg == '0)
        begin
            // stray byte outside a unit
        end
        else if (!frag_mode_reg)
        begin
            unit_left_next  = unit_left_dec;
            result.count    = RES_CNT_W'(1);
            result.slots[0] = '{data: nal_byte, first: 1'b0, last: (unit_left_dec == '0)};
            if (unit_left_dec == '0)
            begin
                seq_bump  = 1'b1;
                unit_done = 1'b1;
            end
        end
        else
        begin
            if (frag_left_reg == '0)
            begin
                // open a fragment: choose its size and FU header flags
                if (start_pend_reg)
                begin
                    fu_hdr          = fu_hdr | FLAG_START;
                    start_pend_next = 1'b0;
                    if (unit_left_reg <= lim_ext)
                        frag_size = unit_left_dec[LIMIT_W-1:0];
                end
                else if (unit_left_reg <= lim_ext)
                begin
                    fu_hdr    = fu_hdr | FLAG_END;
                    frag_size = unit_left_reg[LIMIT_W-1:0];
                end
                frag_left_dec   = frag_size - LIMIT_W'(1);
                result.count    = RES_CNT_W'(3);
                result.slots[0] = '{data: fu_ind, first: 1'b1, last: 1'b0};
                result.slots[1] = '{data: fu_hdr, first: 1'b0, last: 1'b0};
                result.slots[2] = '{data: nal_byte, first: 1'b0,
                                    last: (frag_left_dec == '0)};
            end
            else
            begin
                result.count    = RES_CNT_W'(1);
                result.slots[0] = '{data: nal_byte, first: 1'b0,
                                    last: (frag_left_dec == '0)};
            end
            frag_left_next = frag_left_dec;
            unit_left_next = unit_left_dec;
            seq_bump       = (frag_left_dec == '0);
            unit_done      = (unit_left_dec == '0);
        end

        result.seq = seq_cur;
        result.ts  = ts_cur;
        seq_next   = seq_cur + SEQ_W'(seq_bump);
        ts_next    = ts_cur + (unit_done ? TS_W'(step_reg) : '0);
    end

    // State update on every accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frag_mode_reg  <= 1'b0;
            header_reg     <= '0;
            unit_left_reg  <= '0;
            frag_left_reg  <= '0;
            start_pend_reg <= 1'b0;
            seq_reg        <= '0;
            ts_reg         <= '0;
        end
        else if (accept)
        begin
            frag_mode_reg  <= frag_mode_next;
            header_reg     <= header_next;
            unit_left_reg  <= unit_left_next;
            frag_left_reg  <= frag_left_next;
            start_pend_reg <= start_pend_next;
            seq_reg        <= seq_next;
            ts_reg         <= ts_next;
        end
    end

endmodule

@@ src/nalfu_out_buf.sv @@
// Result register: holds up to three payload bytes and shifts them out.
module nalfu_out_buf (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load,
    input  nalfu_pkg::step_result_t  result,
    output logic                     can_load,
    nalfu_out_if.source              out_port
);
    import nalfu_pkg::*;

    slot_t [MAX_RESULTS-1:0] slot_reg;
    logic [RES_CNT_W-1:0]    cnt_reg;
    logic [SEQ_W-1:0]        seq_reg;
    logic [TS_W-1:0]         ts_reg;
    logic                    fire;

    // a new item may enter when the buffer is empty or empties this cycle
    assign fire     = (cnt_reg != '0) && out_port.ready;
    assign can_load = (cnt_reg == '0) || ((cnt_reg == RES_CNT_W'(1)) && out_port.ready);

    // Occupancy count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (load)
            cnt_reg <= result.count;
        else if (fire)
            cnt_reg <= cnt_reg - RES_CNT_W'(1);
    end

    // Payload slots, shifted towards slot 0 on each transfer
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot_reg <= result.slots;
            seq_reg  <= result.seq;
            ts_reg   <= result.ts;
        end
        else if (fire)
        begin
            for (int i = 0; i < MAX_RESULTS - 1; i++)
                slot_reg[i] <= slot_reg[i+1];
        end
    end

    assign out_port.valid           = (cnt_reg != '0);
    assign out_port.payload_byte    = slot_reg[0].data;
    assign out_port.packet_first    = slot_reg[0].first;
    assign out_port.packet_last     = slot_reg[0].last;
    assign out_port.sequence_number = seq_reg;
    assign out_port.time_stamp      = ts_reg;
    assign out_port.run_last        = (cnt_reg == RES_CNT_W'(1));

endmodule

@@ src/h264_nal_rtp_fu_a_packetizer_unit.sv @@
// H.264 NAL unit to RTP payload packetizer (single NAL unit and FU-A modes).
// Latency: the first payload byte of an item is registered and appears in the cycle after its transfer.
// Throughput: one input byte per cycle while the output is ready; a byte that opens a fragment
//   yields three payload bytes and holds input ready low until the output result register is down to its last byte.
// Reset: asynchronous active low; counters, sequence, timestamp and buffer clear,
//   fragment limit resets to 1400 and timestamp step to 3600.
module h264_nal_rtp_fu_a_packetizer_unit #(
    parameter int MAX_UNIT_LENGTH_BITS = 24
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [nalfu_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [nalfu_pkg::CFG_DATA_W-1:0]   cfg_data,
    nalfu_in_if.sink                           in_port,
    nalfu_out_if.source                        out_port
);
    import nalfu_pkg::*;

    step_result_t result;
    logic         can_load;
    logic         accept;

    assign in_port.ready = can_load;
    assign accept        = in_port.valid && can_load;

    // Per-byte step logic and state
    nalfu_step #(
        .MAX_UNIT_LENGTH_BITS(MAX_UNIT_LENGTH_BITS)
    ) u_step (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .accept       (accept),
        .nal_byte     (in_port.nal_byte),
        .first_of_unit(in_port.first_of_unit),
        .unit_length  (in_port.unit_length),
        .result       (result)
    );

    // Output result register
    nalfu_out_buf u_out_buf (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (accept),
        .result  (result),
        .can_load(can_load),
        .out_port(out_port)
    );

endmodule

@@ src/nalfu_checker.sv @@
// Port-level checker for the packetizer, bound to the top level.
`include "assert_macros.svh"

module nalfu_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [nalfu_pkg::NAL_BYTE_W-1:0] payload_byte,
    input logic                           packet_first,
    input logic                           packet_last,
    input logic [nalfu_pkg::SEQ_W-1:0]    sequence_number,
    input logic [nalfu_pkg::TS_W-1:0]     time_stamp,
    input logic                           run_last
);

    // stalled output holds its payload byte
    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(payload_byte))

    // stalled output holds its packet and run flags
    `ASSERT_NEXT(a_flag_hold, out_valid && !out_ready, $stable({packet_first, packet_last, run_last}))

    // input is only refused while results are still waiting
    `ASSERT_SAME(a_ready_busy, in_valid && !in_ready, out_valid)

    // a run that is not finished keeps the output valid
    `ASSERT_NEXT(a_run_continues, out_valid && out_ready && !run_last, out_valid)

    // bytes of one run share sequence number and timestamp
    `ASSERT_NEXT(a_run_shared, out_valid && out_ready && !run_last, $stable({sequence_number, time_stamp}))

endmodule

bind h264_nal_rtp_fu_a_packetizer_unit nalfu_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_port.valid),
    .in_ready       (in_port.ready),
    .out_valid      (out_port.valid),
    .out_ready      (out_port.ready),
    .payload_byte   (out_port.payload_byte),
    .packet_first   (out_port.packet_first),
    .packet_last    (out_port.packet_last),
    .sequence_number(out_port.sequence_number),
    .time_stamp     (out_port.time_stamp),
    .run_last       (out_port.run_last)
);

@@ sim/testbench.sv @@
// Self-checking testbench for the H.264 NAL to RTP FU-A packetizer unit.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import nalfu_pkg::*;

    localparam int STALL_LIMIT = 1000;

    // One payload byte as seen on the output channel
    typedef struct packed {
        logic [NAL_BYTE_W-1:0] payload_byte;
        logic                  packet_first;
        logic                  packet_last;
        logic [SEQ_W-1:0]      sequence_number;
        logic [TS_W-1:0]       time_stamp;
        logic                  run_last;
    } payload_rec_t;

    // Packetizer state mirror plus the queue of payload bytes still due
    class rtp_payload_scoreboard;
        payload_rec_t          due_payload[$];
        payload_rec_t          step_bytes[$];
        int unsigned           error_count;

        logic [LIMIT_W-1:0]    fragment_limit;
        logic [STEP_W-1:0]     timestamp_step;
        bit                    fragment_mode;
        logic [NAL_BYTE_W-1:0] unit_header;
        logic [UNIT_LEN_W-1:0] unit_bytes_left;
        logic [LIMIT_W-1:0]    fragment_bytes_left;
        bit                    start_pending;
        logic [SEQ_W-1:0]      packet_seq;
        logic [TS_W-1:0]       unit_ts;

        function new();
            fragment_limit      = LIMIT_RESET;
            timestamp_step      = STEP_RESET;
            fragment_mode       = 1'b0;
            unit_header         = '0;
            unit_bytes_left     = '0;
            fragment_bytes_left = '0;
            start_pending       = 1'b0;
            packet_seq          = '0;
            unit_ts             = '0;
            error_count         = 0;
        endfunction

        function void write_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_FRAGMENT_LIMIT: fragment_limit = value[LIMIT_W-1:0];
                CFG_TIMESTAMP_STEP: timestamp_step = value[STEP_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned outstanding();
            return due_payload.size();
        endfunction

        function void emit(logic [NAL_BYTE_W-1:0] b, logic pf, logic pl);
            payload_rec_t rec;
            rec.payload_byte    = b;
            rec.packet_first    = pf;
            rec.packet_last     = pl;
            rec.sequence_number = packet_seq;
            rec.time_stamp      = unit_ts;
            rec.run_last        = 1'b0;
            step_bytes.push_back(rec);
        endfunction

        function logic [NAL_BYTE_W-1:0] fu_indicator();
            return (unit_header & F_NRI_MASK) | FU_A_TYPE;
        endfunction

        // Work out the payload bytes caused by one accepted NAL byte
        function void note_nal_byte(logic [NAL_BYTE_W-1:0] nal, logic first,
                                    logic [UNIT_LEN_W-1:0] len_in);
            logic [UNIT_LEN_W-1:0] len;
            logic [LIMIT_W-1:0]    lim;
            logic [NAL_BYTE_W-1:0] fu_head;
            logic [LIMIT_W-1:0]    frag_size;
            len = len_in;
            lim = (fragment_limit == 0) ? LIMIT_W'(1) : fragment_limit;
            step_bytes.delete();
            if (first)
            begin
                // a new header abandons any unit still in progress
                if (unit_bytes_left != 0)
                begin
                    if (!fragment_mode || fragment_bytes_left != 0)
                        packet_seq = packet_seq + 1'b1;
                    unit_ts = unit_ts + timestamp_step;
                end
                if (len == 0)
                    len = 1;
                unit_header         = nal;
                fragment_bytes_left = '0;
                start_pending       = 1'b0;
                unit_bytes_left     = len - 1'b1;
                if (len <= lim)
                begin
                    fragment_mode = 1'b0;
                    emit(nal, 1'b1, len == 1);
                    if (len == 1)
                    begin
                        packet_seq = packet_seq + 1'b1;
                        unit_ts    = unit_ts + timestamp_step;
                    end
                end
                else
                begin
                    fragment_mode = 1'b1;
                    start_pending = 1'b1;
                    // one data byte only: start fragment goes out with no data
                    if (unit_bytes_left == 1)
                    begin
                        emit(fu_indicator(), 1'b1, 1'b0);
                        emit(FLAG_START | (unit_header & TYPE_MASK), 1'b0, 1'b1);
                        packet_seq    = packet_seq + 1'b1;
                        start_pending = 1'b0;
                    end
                end
            end
            else if (unit_bytes_left != 0)
            begin
                if (!fragment_mode)
                begin
                    unit_bytes_left = unit_bytes_left - 1'b1;
                    emit(nal, 1'b0, unit_bytes_left == 0);
                    if (unit_bytes_left == 0)
                    begin
                        packet_seq = packet_seq + 1'b1;
                        unit_ts    = unit_ts + timestamp_step;
                    end
                end
                else
                begin
                    // open a fragment: indicator and FU header first
                    if (fragment_bytes_left == 0)
                    begin
                        fu_head = unit_header & TYPE_MASK;
                        if (start_pending)
                        begin
                            fu_head       = fu_head | FLAG_START;
                            frag_size     = (unit_bytes_left <= lim) ?
                                            LIMIT_W'(unit_bytes_left - 1'b1) : lim;
                            start_pending = 1'b0;
                        end
                        else if (unit_bytes_left <= lim)
                        begin
                            fu_head   = fu_head | FLAG_END;
                            frag_size = LIMIT_W'(unit_bytes_left);
                        end
                        else
                            frag_size = lim;
                        emit(fu_indicator(), 1'b1, 1'b0);
                        emit(fu_head, 1'b0, 1'b0);
                        fragment_bytes_left = frag_size;
                    end
                    fragment_bytes_left = fragment_bytes_left - 1'b1;
                    unit_bytes_left     = unit_bytes_left - 1'b1;
                    emit(nal, 1'b0, fragment_bytes_left == 0);
                    if (fragment_bytes_left == 0)
                        packet_seq = packet_seq + 1'b1;
                    if (unit_bytes_left == 0)
                        unit_ts = unit_ts + timestamp_step;
                end
            end
            if (step_bytes.size() > 0)
                step_bytes[step_bytes.size()-1].run_last = 1'b1;
            foreach (step_bytes[i])
                due_payload.push_back(step_bytes[i]);
        endfunction

        function void compare_field(string name, longint unsigned exp_v,
                                    longint unsigned act_v);
            if (exp_v != act_v)
            begin
                $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
                error_count++;
            end
        endfunction

        function void check_payload_byte(payload_rec_t got);
            payload_rec_t exp_rec;
            if (due_payload.size() == 0)
            begin
                $error("payload byte 0x%0h with nothing expected", got.payload_byte);
                error_count++;
                return;
            end
            exp_rec = due_payload.pop_front();
            compare_field("payload_byte", exp_rec.payload_byte, got.payload_byte);
            compare_field("packet_first", exp_rec.packet_first, got.packet_first);
            compare_field("packet_last", exp_rec.packet_last, got.packet_last);
            compare_field("sequence_number", exp_rec.sequence_number,
                          got.sequence_number);
            compare_field("time_stamp", exp_rec.time_stamp, got.time_stamp);
            compare_field("run_last", exp_rec.run_last, got.run_last);
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    cfg_index_t            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    nalfu_in_if  in_if ();
    nalfu_out_if out_if ();

    rtp_payload_scoreboard sb = new();

    bit                 idling;
    logic [LIMIT_W-1:0] cur_limit;
    int unsigned        quiet_cycles;

    h264_nal_rtp_fu_a_packetizer_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_port   (in_if),
        .out_port  (out_if)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Output back-pressure
    initial
    begin
        out_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_if.ready <= !(idling && $urandom_range(99) < 6);
        end
    end

    // Transfer monitor and stall watchdog
    always @(posedge clk)
    begin : monitor
        payload_rec_t got;
        bit           moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (in_if.valid && in_if.ready)
            begin
                sb.note_nal_byte(in_if.nal_byte, in_if.first_of_unit, in_if.unit_length);
                moved = 1'b1;
            end
            if (out_if.valid && out_if.ready)
            begin
                got.payload_byte    = out_if.payload_byte;
                got.packet_first    = out_if.packet_first;
                got.packet_last     = out_if.packet_last;
                got.sequence_number = out_if.sequence_number;
                got.time_stamp      = out_if.time_stamp;
                got.run_last        = out_if.run_last;
                sb.check_payload_byte(got);
                moved = 1'b1;
            end
            quiet_cycles <= moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // One input transfer, with an occasional gap before it
    task automatic send_item(logic [NAL_BYTE_W-1:0] b, logic first,
                             logic [UNIT_LEN_W-1:0] len);
        while (idling && $urandom_range(99) < 6)
        begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid         <= 1'b1;
        in_if.nal_byte      <= b;
        in_if.first_of_unit <= first;
        in_if.unit_length   <= len;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
    endtask

    // Header byte followed by n_data data bytes (junk in the length field)
    task automatic send_unit(logic [NAL_BYTE_W-1:0] hdr, logic [UNIT_LEN_W-1:0] len,
                             int n_data);
        send_item(hdr, 1'b1, len);
        repeat (n_data)
            send_item(NAL_BYTE_W'($urandom_range(0, 255)), 1'b0, UNIT_LEN_W'($urandom()));
    endtask

    // Drain all expected bytes, then let any absorbed header settle
    task automatic quiesce();
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_config(logic [LIMIT_W-1:0] limit, logic [STEP_W-1:0] ts_step,
                                logic [CFG_DATA_W-LIMIT_W-1:0] pad);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FRAGMENT_LIMIT;
        cfg_data  <= {pad, limit};
        @(posedge clk);
        sb.write_register(CFG_FRAGMENT_LIMIT, {pad, limit});
        cfg_index <= CFG_TIMESTAMP_STEP;
        cfg_data  <= ts_step;
        @(posedge clk);
        sb.write_register(CFG_TIMESTAMP_STEP, ts_step);
        cfg_we    <= 1'b0;
        cur_limit = limit;
    endtask

    // Mostly well-formed units, some truncated, huge or zero length, plus stray bytes
    task automatic run_random(int n_items);
        int                    sent;
        int                    n_data;
        int                    cap;
        int unsigned           pick;
        logic [UNIT_LEN_W-1:0] len;
        logic [LIMIT_W-1:0]    lim_eff;
        sent    = 0;
        lim_eff = (cur_limit == 0) ? LIMIT_W'(1) : cur_limit;
        cap     = (int'(lim_eff) * 3 + 2 > 24) ? 24 : int'(lim_eff) * 3 + 2;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
            begin
                len    = UNIT_LEN_W'($urandom());
                n_data = $urandom_range(0, 12);
            end
            else if (pick < 15)
            begin
                len    = '0;
                n_data = 0;
            end
            else
            begin
                len    = UNIT_LEN_W'($urandom_range(1, cap));
                n_data = int'(len) - 1;
                if ($urandom_range(99) < 10)
                    n_data = $urandom_range(0, n_data);
            end
            if (n_data > int'(len) - 1 && len != 0)
                n_data = int'(len) - 1;
            send_unit(NAL_BYTE_W'($urandom_range(0, 255)), len, n_data);
            sent += 1 + n_data;
            // stray byte between units
            if ($urandom_range(99) < 8)
                send_item(NAL_BYTE_W'($urandom_range(0, 255)), 1'b0,
                          UNIT_LEN_W'($urandom()));
        end
    endtask

    // Main sequence
    initial
    begin
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_index           <= CFG_FRAGMENT_LIMIT;
        cfg_data            <= '0;
        in_if.valid         <= 1'b0;
        in_if.nal_byte      <= '0;
        in_if.first_of_unit <= 1'b0;
        in_if.unit_length   <= '0;
        quiet_cycles        <= 0;
        idling              = 1'b1;
        cur_limit           = LIMIT_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: stray byte, one-byte unit, zero length
        send_item(8'hFF, 1'b0, 24'hFFFFFF);
        send_unit(8'h00, 24'd1, 0);
        send_unit(8'hFF, 24'd0, 0);
        quiesce();

        // Small limit: fragmentation, F bit copy, abandoned units
        write_config(11'd3, 17'h1FFFF, 6'h3F);
        send_unit(8'hE5, 24'd6, 5);
        send_unit(8'h41, 24'd5, 2);
        send_unit(8'hA7, 24'd3, 1);
        send_unit(8'h7C, 24'd9, 2);
        quiesce();

        // Limit drops mid unit; then the data-less start fragment
        write_config(11'd1, 17'd0, 6'h00);
        repeat (6)
            send_item(NAL_BYTE_W'($urandom_range(0, 255)), 1'b0, UNIT_LEN_W'($urandom()));
        send_unit(8'h60, 24'd2, 1);
        quiesce();

        write_config(11'd4, 17'd3600, 6'(($urandom())));
        run_random(14);
        quiesce();

        write_config(11'd0, 17'd90000, 6'(($urandom())));
        run_random(14);
        quiesce();

        // Stretch without any idling on either side
        idling = 1'b0;
        write_config(11'h7FF, 17'd1, 6'(($urandom())));
        run_random(30);
        quiesce();

        idling = 1'b1;
        write_config(LIMIT_W'($urandom_range(1, 8)), STEP_W'($urandom_range(0, 131071)),
                     6'(($urandom())));
        run_random(14);
        quiesce();

        write_config(LIMIT_RESET, STEP_RESET, 6'h00);
        run_random(14);
        quiesce();

        if (sb.error_count == 0 && sb.outstanding() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
